[hw/rtl/bchk_pkg.sv]
// Shared constants and helpers for the bounding-box Hilbert key block.
package bchk_pkg;

  localparam int unsigned GRID_BITS = 16;
  localparam int unsigned KEY_BITS  = 32;
  localparam logic [GRID_BITS-1:0] GRID_MAX = 16'hFFFF;

  localparam int unsigned REG_COUNT = 4;
  localparam int unsigned CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_EXT_MIN_X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXT_MAX_X = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXT_MIN_Y = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXT_MAX_Y = 3'd3;

  // Interleave two grid words: lo goes to even bits, hi to odd bits.
  function automatic logic [KEY_BITS-1:0] interleave(input logic [GRID_BITS-1:0] lo,
                                                     input logic [GRID_BITS-1:0] hi);
    logic [KEY_BITS-1:0] k;
    k = '0;
    for (int i = 0; i < GRID_BITS; i++) begin
      k[2*i]   = lo[i];
      k[2*i+1] = hi[i];
    end
    return k;
  endfunction

endpackage

[hw/rtl/bchk_div_cell.sv]
// One cell of the scaled-quotient chain: retires one quotient bit per cycle.
module bchk_div_cell #(
  parameter int unsigned DW = 35
) (
  input  logic                               clk,
  input  logic [DW-1:0]                      a_i,
  input  logic [DW-1:0]                      d_i,
  input  logic [DW-1:0]                      rem_i,
  input  logic [bchk_pkg::GRID_BITS-1:0]     q_i,
  input  logic                               ovr_i,
  input  logic                               ovr_val_i,
  output logic [DW-1:0]                      a_o,
  output logic [DW-1:0]                      d_o,
  output logic [DW-1:0]                      rem_o,
  output logic [bchk_pkg::GRID_BITS-1:0]     q_o,
  output logic                               ovr_o,
  output logic                               ovr_val_o
);

  logic [DW:0]                        rem2;
  logic [DW:0]                        d1;
  logic [DW:0]                        d2;
  logic                               ge1;
  logic                               ge2;
  logic [DW:0]                        rem_sub;
  logic [DW-1:0]                      rem_nxt;
  logic [bchk_pkg::GRID_BITS-1:0]     q_nxt;
  logic [DW-1:0]                      a_r;
  logic [DW-1:0]                      d_r;
  logic [DW-1:0]                      rem_r;
  logic [bchk_pkg::GRID_BITS-1:0]     q_r;
  logic                               ovr_r;
  logic                               ovr_val_r;

  // Remainder doubles and takes one more copy of the numerator (scale is all ones).
  always_comb begin
    rem2 = {rem_i, 1'b0} + {1'b0, a_i};
    d1   = {1'b0, d_i};
    d2   = {d_i, 1'b0};
    ge2  = (rem2 >= d2);
    ge1  = (rem2 >= d1);
    if (ge2) begin
      rem_sub = rem2 - d2;
    end else if (ge1) begin
      rem_sub = rem2 - d1;
    end else begin
      rem_sub = rem2;
    end
    rem_nxt = rem_sub[DW-1:0];
    q_nxt   = {q_i[bchk_pkg::GRID_BITS-2:0], 1'b0}
            + {{(bchk_pkg::GRID_BITS-2){1'b0}}, ge2, ge1 & ~ge2};
  end

  always_ff @(posedge clk) begin
    a_r       <= a_i;
    d_r       <= d_i;
    rem_r     <= rem_nxt;
    q_r       <= q_nxt;
    ovr_r     <= ovr_i;
    ovr_val_r <= ovr_val_i;
  end

  assign a_o       = a_r;
  assign d_o       = d_r;
  assign rem_o     = rem_r;
  assign q_o       = q_r;
  assign ovr_o     = ovr_r;
  assign ovr_val_o = ovr_val_r;

endmodule

[hw/rtl/bchk_curve.sv]
// Branchless order-16 Hilbert index of two grid words, registered output.
module bchk_curve (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               valid_i,
  input  logic [bchk_pkg::GRID_BITS-1:0]     gx_i,
  input  logic [bchk_pkg::GRID_BITS-1:0]     gy_i,
  output logic                               valid_o,
  output logic [bchk_pkg::KEY_BITS-1:0]      key_o
);

  localparam int unsigned G = bchk_pkg::GRID_BITS;

  logic [G-1:0] p0, q0, r0, s0;
  logic [G-1:0] p1, q1, r1, s1;
  logic [G-1:0] p2, q2, r2, s2;
  logic [G-1:0] p3, q3, r3, s3;
  logic [G-1:0] r4, s4;
  logic [G-1:0] pf, qf, e0, e1;
  logic [bchk_pkg::KEY_BITS-1:0] key_nxt;
  logic [bchk_pkg::KEY_BITS-1:0] key_r;
  logic                          valid_r;

  always_comb begin
    p0 = gx_i ^ gy_i;
    q0 = bchk_pkg::GRID_MAX ^ p0;
    r0 = bchk_pkg::GRID_MAX ^ (gx_i | gy_i);
    s0 = gx_i & (gy_i ^ bchk_pkg::GRID_MAX);

    p1 = p0 | (q0 >> 1);
    q1 = (p0 >> 1) ^ p0;
    r1 = ((r0 >> 1) ^ (q0 & (s0 >> 1))) ^ r0;
    s1 = ((p0 & (r0 >> 1)) ^ (s0 >> 1)) ^ s0;

    p2 = (p1 & (p1 >> 2)) ^ (q1 & (q1 >> 2));
    q2 = (p1 & (q1 >> 2)) ^ (q1 & ((p1 ^ q1) >> 2));
    r2 = r1 ^ ((p1 & (r1 >> 2)) ^ (q1 & (s1 >> 2)));
    s2 = s1 ^ ((q1 & (r1 >> 2)) ^ ((p1 ^ q1) & (s1 >> 2)));

    p3 = (p2 & (p2 >> 4)) ^ (q2 & (q2 >> 4));
    q3 = (p2 & (q2 >> 4)) ^ (q2 & ((p2 ^ q2) >> 4));
    r3 = r2 ^ ((p2 & (r2 >> 4)) ^ (q2 & (s2 >> 4)));
    s3 = s2 ^ ((q2 & (r2 >> 4)) ^ ((p2 ^ q2) & (s2 >> 4)));

    r4 = r3 ^ ((p3 & (r3 >> 8)) ^ (q3 & (s3 >> 8)));
    s4 = s3 ^ ((q3 & (r3 >> 8)) ^ ((p3 ^ q3) & (s3 >> 8)));

    pf = r4 ^ (r4 >> 1);
    qf = s4 ^ (s4 >> 1);

    e0 = gx_i ^ gy_i;
    e1 = qf | (bchk_pkg::GRID_MAX ^ (e0 | pf));

    key_nxt = bchk_pkg::interleave(e0, e1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign valid_o = valid_r;
  assign key_o   = key_r;

endmodule

[hw/rtl/bbox_center_hilbert_key.sv]
// Top level: box centre normalization and 32-bit Hilbert key, one box per cycle.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------------
//  input   | in_box_min_x/max_x/min_y/max_y          | start & !busy takes a word
//  result  | out_curve_index                         | out_valid strobe, 1 cycle
//  config  | cfg_we, cfg_index, cfg_wdata            | write on cfg_we, no wait
//
// A box enters every cycle; busy is never raised. From accept to strobe each
// word passes a register for numerator and divisor, one after folding signs
// and picking out saturated cases, sixteen cells of the quotient chain (one
// quotient bit each), and the curve logic with its output register.
// Synchronous active-low reset clears the valid pipe and the extent registers.
// The receiver cannot stall, so words never back up.
module bbox_center_hilbert_key #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [COORD_BITS-1:0]          in_box_min_x,
  input  logic signed [COORD_BITS-1:0]          in_box_max_x,
  input  logic signed [COORD_BITS-1:0]          in_box_min_y,
  input  logic signed [COORD_BITS-1:0]          in_box_max_y,
  output logic                                  out_valid,
  output logic [bchk_pkg::KEY_BITS-1:0]         out_curve_index,
  input  logic                                  cfg_we,
  input  logic [bchk_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [COORD_BITS-1:0]                 cfg_wdata
);

  // Numerator and divisor need three bits of headroom over a coordinate.
  localparam int unsigned DW    = COORD_BITS + 3;
  localparam int unsigned STEPS = bchk_pkg::GRID_BITS;

  logic signed [COORD_BITS-1:0] ext_min_x_r, ext_max_x_r, ext_min_y_r, ext_max_y_r;

  logic                  acc;
  logic                  v_a_r;
  logic signed [DW-1:0]  num_x_r, den_x_r, num_y_r, den_y_r;
  logic                  v_b_r;
  logic [DW-1:0]         a_x_r, d_x_r, a_y_r, d_y_r;
  logic                  ovr_x_r, ovr_val_x_r, ovr_y_r, ovr_val_y_r;
  logic [DW-1:0]         a_x_nxt, d_x_nxt, a_y_nxt, d_y_nxt;
  logic                  ovr_x_nxt, ovr_val_x_nxt, ovr_y_nxt, ovr_val_y_nxt;
  logic [STEPS-1:0]      v_chain_r;

  logic [DW-1:0]                     cx_a [0:STEPS];
  logic [DW-1:0]                     cx_d [0:STEPS];
  logic [DW-1:0]                     cx_rem [0:STEPS];
  logic [bchk_pkg::GRID_BITS-1:0]    cx_q [0:STEPS];
  logic                              cx_ovr [0:STEPS];
  logic                              cx_ovv [0:STEPS];
  logic [DW-1:0]                     cy_a [0:STEPS];
  logic [DW-1:0]                     cy_d [0:STEPS];
  logic [DW-1:0]                     cy_rem [0:STEPS];
  logic [bchk_pkg::GRID_BITS-1:0]    cy_q [0:STEPS];
  logic                              cy_ovr [0:STEPS];
  logic                              cy_ovv [0:STEPS];

  logic [bchk_pkg::GRID_BITS-1:0]    gx, gy;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  // Extent registers; writes past the list fall through and are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_min_x_r <= '0;
      ext_max_x_r <= '0;
      ext_min_y_r <= '0;
      ext_max_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bchk_pkg::REG_EXT_MIN_X: ext_min_x_r <= cfg_wdata;
        bchk_pkg::REG_EXT_MAX_X: ext_max_x_r <= cfg_wdata;
        bchk_pkg::REG_EXT_MIN_Y: ext_min_y_r <= cfg_wdata;
        bchk_pkg::REG_EXT_MAX_Y: ext_max_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Valid pipe: front two stages plus one flag per chain cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r     <= 1'b0;
      v_b_r     <= 1'b0;
      v_chain_r <= '0;
    end else begin
      v_a_r     <= acc;
      v_b_r     <= v_a_r;
      v_chain_r <= {v_chain_r[STEPS-2:0], v_b_r};
    end
  end

  // Stage A: numerator = min + max - 2*ext_min, divisor = 2*(ext_max - ext_min).
  always_ff @(posedge clk) begin
    num_x_r <= {{3{in_box_min_x[COORD_BITS-1]}}, in_box_min_x}
             + {{3{in_box_max_x[COORD_BITS-1]}}, in_box_max_x}
             - {{2{ext_min_x_r[COORD_BITS-1]}}, ext_min_x_r, 1'b0};
    den_x_r <= {{2{ext_max_x_r[COORD_BITS-1]}}, ext_max_x_r, 1'b0}
             - {{2{ext_min_x_r[COORD_BITS-1]}}, ext_min_x_r, 1'b0};
    num_y_r <= {{3{in_box_min_y[COORD_BITS-1]}}, in_box_min_y}
             + {{3{in_box_max_y[COORD_BITS-1]}}, in_box_max_y}
             - {{2{ext_min_y_r[COORD_BITS-1]}}, ext_min_y_r, 1'b0};
    den_y_r <= {{2{ext_max_y_r[COORD_BITS-1]}}, ext_max_y_r, 1'b0}
             - {{2{ext_min_y_r[COORD_BITS-1]}}, ext_min_y_r, 1'b0};
  end

  // Stage B: fold a negative divisor into the numerator, then flag clamps.
  always_comb begin
    logic signed [DW-1:0] nx, dx, ny, dy;
    nx = den_x_r[DW-1] ? -num_x_r : num_x_r;
    dx = den_x_r[DW-1] ? -den_x_r : den_x_r;
    ny = den_y_r[DW-1] ? -num_y_r : num_y_r;
    dy = den_y_r[DW-1] ? -den_y_r : den_y_r;

    a_x_nxt = nx;
    d_x_nxt = dx;
    if (den_x_r == '0) begin
      ovr_x_nxt     = 1'b1;
      ovr_val_x_nxt = (num_x_r > 0);
    end else begin
      ovr_x_nxt     = (nx <= 0) || (nx >= dx);
      ovr_val_x_nxt = (nx > 0);
    end

    a_y_nxt = ny;
    d_y_nxt = dy;
    if (den_y_r == '0) begin
      ovr_y_nxt     = 1'b1;
      ovr_val_y_nxt = (num_y_r > 0);
    end else begin
      ovr_y_nxt     = (ny <= 0) || (ny >= dy);
      ovr_val_y_nxt = (ny > 0);
    end
  end

  always_ff @(posedge clk) begin
    a_x_r       <= a_x_nxt;
    d_x_r       <= d_x_nxt;
    ovr_x_r     <= ovr_x_nxt;
    ovr_val_x_r <= ovr_val_x_nxt;
    a_y_r       <= a_y_nxt;
    d_y_r       <= d_y_nxt;
    ovr_y_r     <= ovr_y_nxt;
    ovr_val_y_r <= ovr_val_y_nxt;
  end

  // Chain heads: remainder and quotient start at zero.
  assign cx_a[0]   = a_x_r;
  assign cx_d[0]   = d_x_r;
  assign cx_rem[0] = '0;
  assign cx_q[0]   = '0;
  assign cx_ovr[0] = ovr_x_r;
  assign cx_ovv[0] = ovr_val_x_r;
  assign cy_a[0]   = a_y_r;
  assign cy_d[0]   = d_y_r;
  assign cy_rem[0] = '0;
  assign cy_q[0]   = '0;
  assign cy_ovr[0] = ovr_y_r;
  assign cy_ovv[0] = ovr_val_y_r;

  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    bchk_div_cell #(.DW(DW)) u_cx (
      .clk       (clk),
      .a_i       (cx_a[k]),
      .d_i       (cx_d[k]),
      .rem_i     (cx_rem[k]),
      .q_i       (cx_q[k]),
      .ovr_i     (cx_ovr[k]),
      .ovr_val_i (cx_ovv[k]),
      .a_o       (cx_a[k+1]),
      .d_o       (cx_d[k+1]),
      .rem_o     (cx_rem[k+1]),
      .q_o       (cx_q[k+1]),
      .ovr_o     (cx_ovr[k+1]),
      .ovr_val_o (cx_ovv[k+1])
    );
    bchk_div_cell #(.DW(DW)) u_cy (
      .clk       (clk),
      .a_i       (cy_a[k]),
      .d_i       (cy_d[k]),
      .rem_i     (cy_rem[k]),
      .q_i       (cy_q[k]),
      .ovr_i     (cy_ovr[k]),
      .ovr_val_i (cy_ovv[k]),
      .a_o       (cy_a[k+1]),
      .d_o       (cy_d[k+1]),
      .rem_o     (cy_rem[k+1]),
      .q_o       (cy_q[k+1]),
      .ovr_o     (cy_ovr[k+1]),
      .ovr_val_o (cy_ovv[k+1])
    );
  end

  // Clamped axes replace the quotient with all zeros or all ones.
  assign gx = cx_ovr[STEPS] ? {bchk_pkg::GRID_BITS{cx_ovv[STEPS]}} : cx_q[STEPS];
  assign gy = cy_ovr[STEPS] ? {bchk_pkg::GRID_BITS{cy_ovv[STEPS]}} : cy_q[STEPS];

  bchk_curve u_curve (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (v_chain_r[STEPS-1]),
    .gx_i    (gx),
    .gy_i    (gy),
    .valid_o (out_valid),
    .key_o   (out_curve_index)
  );

endmodule
